// ===== src/lef_pkg.sv =====
// Shared types, constants and helpers for the 3x3 Laplacian edge filter.
// Used by all filter modules but the line store; depends on nothing else.
package lef_pkg;

  localparam int PixW            = 8;
  localparam int ColorSumW       = 10;
  localparam int GrayProdW       = 2 * ColorSumW;
  localparam int GrayRecip       = 683;
  localparam int GrayShift       = 11;
  localparam int LapW            = 10;
  localparam int CenterShift     = 2;
  localparam int MaxWidthDefault = 1024;
  localparam int MaxHeightDefault = 4096;
  localparam int WidthRegW       = 11;
  localparam int HeightRegW      = 13;
  localparam int CfgDataW        = 13;
  localparam int CfgIdxW         = 1;
  localparam int MinSize         = 3;
  localparam int SizeReset       = 100;

  typedef enum logic [CfgIdxW-1:0] {
    RegImageWidth  = 1'b0,
    RegImageHeight = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CmdPixel = 1'b0,
    CmdFlush = 1'b1
  } cmd_e;

  typedef struct packed {
    logic pix;
    logic has_out;
    logic interior;
    logic frame_end;
  } stage_ctrl_t;

  function automatic int clamp_size(int v, int hi);
    int r;
    r = v;
    if (r < MinSize) r = MinSize;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== src/lef_gray.sv =====
// Color to gray conversion: the channel sum divided by three, truncated.
// Depends on lef_pkg for widths and the reciprocal constant.
module lef_gray (
  input  logic [lef_pkg::PixW-1:0] blue_i,
  input  logic [lef_pkg::PixW-1:0] green_i,
  input  logic [lef_pkg::PixW-1:0] red_i,
  output logic [lef_pkg::PixW-1:0] gray_o
);

  logic [lef_pkg::ColorSumW-1:0] sum;
  logic [lef_pkg::GrayProdW-1:0] prod;

  assign sum = lef_pkg::ColorSumW'(blue_i) + lef_pkg::ColorSumW'(green_i)
             + lef_pkg::ColorSumW'(red_i);

  // The reciprocal is exact for every sum below 2048.
  assign prod = lef_pkg::GrayProdW'(sum) * lef_pkg::GrayProdW'(lef_pkg::GrayRecip);

  assign gray_o = prod[lef_pkg::GrayShift +: lef_pkg::PixW];

endmodule

// ===== src/lef_line_store.sv =====
// Line store memory holding the gray values of the two previous rows.
// One write and one registered read per cycle; no package dependency.
module lef_line_store #(
  parameter int Depth = 1024,
  parameter int AddrW = 10,
  parameter int DataW = 16
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/lef_window.sv =====
// 3x3 window registers and the 4-neighbour Laplacian, floored at zero.
// Depends on lef_pkg for widths and the stage control struct.
module lef_window (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_en_i,
  input  lef_pkg::stage_ctrl_t     ctrl_i,
  input  logic [lef_pkg::PixW-1:0] upper_i,
  input  logic [lef_pkg::PixW-1:0] lower_i,
  input  logic [lef_pkg::PixW-1:0] gray_i,
  output logic [lef_pkg::PixW-1:0] edge_o
);

  logic [lef_pkg::PixW-1:0] win_q [9];
  logic [lef_pkg::PixW-1:0] win_d [9];
  logic [lef_pkg::LapW-1:0] pos_sum;
  logic [lef_pkg::LapW-1:0] neg_sum;
  logic [lef_pkg::LapW-1:0] diff;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3+0] = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = upper_i;
    win_d[5] = lower_i;
    win_d[8] = gray_i;
  end

  assign pos_sum = lef_pkg::LapW'(win_d[1]) + lef_pkg::LapW'(win_d[7])
                 + lef_pkg::LapW'(win_d[3]) + lef_pkg::LapW'(win_d[5]);
  assign neg_sum = lef_pkg::LapW'(win_d[4]) << lef_pkg::CenterShift;
  assign diff    = pos_sum - neg_sum;

  always_comb begin
    edge_o = '0;
    if (ctrl_i.interior && (pos_sum >= neg_sum)) begin
      edge_o = diff[lef_pkg::PixW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (shift_en_i) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= win_d[k];
      end
    end
  end

endmodule

// ===== src/laplacian_edge_filter_3x3_core.sv =====
// Top level of the 3x3 Laplacian edge filter over a raster color stream.
// Depends on lef_pkg, lef_gray, lef_line_store and lef_window.
//
// Pixels enter on the s_axis channel, one transaction each: tdata carries
// blue, green and red, and tuser set to one marks a flush transaction.
// Results leave on the m_axis channel: tdata is the edge value and tlast
// marks the last output of a frame. Each result belongs to the pixel that
// entered image_width+1 pixels earlier; border positions give zero.
// After the last pixel of a frame, image_width+1 flush transactions drain
// the remaining border zeros; other flushes produce nothing.
// The block takes one transaction per cycle while m_axis is not stalled. A
// result reaches m_axis through the input register, which loads together
// with the line store read when the transaction is accepted, and then the
// output register, which the window and Laplacian fill.
// When a waiting result is not taken, both stages hold and s_axis_tready drops.
// Reset empties the pipeline, clears the window and position counters and
// sets both image sizes to 100; the line store needs no clearing.
// Writes on the configuration port set a size and restart the frame; the user
// must make them only with no transaction in flight; the block does not check.
module laplacian_edge_filter_3x3_core #(
  parameter int MAX_WIDTH  = lef_pkg::MaxWidthDefault,
  parameter int MAX_HEIGHT = lef_pkg::MaxHeightDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lef_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lef_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // Fields from bit 0: blue[7:0], green[15:8], red[23:16].
  input  logic [23:0]                  s_axis_tdata,
  // Fields from bit 0: command.
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // Fields from bit 0: edge_value[7:0].
  output logic [7:0]                   m_axis_tdata,
  output logic                         m_axis_tlast
);

  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int RowW   = $clog2(MAX_HEIGHT);
  localparam int OwedW  = $clog2(MAX_WIDTH + 2);
  localparam int PixW   = lef_pkg::PixW;
  localparam int WLastReset = lef_pkg::clamp_size(lef_pkg::SizeReset, MAX_WIDTH) - 1;
  localparam int HLastReset = lef_pkg::clamp_size(lef_pkg::SizeReset, MAX_HEIGHT) - 1;

  logic [ColW-1:0]  wlast_q, wlast_d;
  logic [RowW-1:0]  hlast_q, hlast_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [OwedW-1:0] owed_q, owed_d;

  logic                 s1_valid_q;
  lef_pkg::stage_ctrl_t s1_ctrl_q, s1_ctrl_d;
  logic [PixW-1:0]      s1_gray_q;
  logic [ColW-1:0]      s1_col_q;

  logic            out_valid_q;
  logic [PixW-1:0] out_edge_q;
  logic            out_last_q;

  logic              pipe_en;
  logic              in_acc;
  logic [PixW-1:0]   gray;
  logic [2*PixW-1:0] rd_data;
  logic              shift_en;
  logic [PixW-1:0]   win_edge;
  logic              last_pix;

  assign pipe_en       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign in_acc        = s_axis_tvalid && pipe_en;
  assign shift_en      = pipe_en && s1_valid_q && s1_ctrl_q.pix;
  assign last_pix      = (row_q == hlast_q) && (col_q == wlast_q);

  lef_gray u_gray (
    .blue_i  (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .red_i   (s_axis_tdata[23:16]),
    .gray_o  (gray)
  );

  lef_line_store #(
    .Depth (MAX_WIDTH),
    .AddrW (ColW),
    .DataW (2 * PixW)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (shift_en),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({rd_data[PixW-1:0], s1_gray_q}),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data)
  );

  lef_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (shift_en),
    .ctrl_i     (s1_ctrl_q),
    .upper_i    (rd_data[2*PixW-1:PixW]),
    .lower_i    (rd_data[PixW-1:0]),
    .gray_i     (s1_gray_q),
    .edge_o     (win_edge)
  );

  always_comb begin
    int size;
    size      = 0;
    wlast_d   = wlast_q;
    hlast_d   = hlast_q;
    col_d     = col_q;
    row_d     = row_q;
    owed_d    = owed_q;
    s1_ctrl_d = '0;
    if (cfg_we_i) begin
      col_d  = '0;
      row_d  = '0;
      owed_d = '0;
      case (lef_pkg::cfg_reg_e'(cfg_index_i))
        lef_pkg::RegImageWidth: begin
          size    = lef_pkg::clamp_size(int'(cfg_data_i[lef_pkg::WidthRegW-1:0]), MAX_WIDTH);
          wlast_d = ColW'(size - 1);
        end
        lef_pkg::RegImageHeight: begin
          size    = lef_pkg::clamp_size(int'(cfg_data_i[lef_pkg::HeightRegW-1:0]),
                                        MAX_HEIGHT);
          hlast_d = RowW'(size - 1);
        end
        default: begin
          col_d  = col_q;
          row_d  = row_q;
          owed_d = owed_q;
        end
      endcase
    end else if (in_acc) begin
      if (lef_pkg::cmd_e'(s_axis_tuser) == lef_pkg::CmdFlush) begin
        s1_ctrl_d.has_out   = (owed_q != '0);
        s1_ctrl_d.frame_end = (owed_q == OwedW'(1));
        if (owed_q != '0) begin
          owed_d = owed_q - OwedW'(1);
        end
      end else begin
        s1_ctrl_d.pix      = 1'b1;
        s1_ctrl_d.has_out  = (row_q != '0) && !((row_q == RowW'(1)) && (col_q == '0));
        s1_ctrl_d.interior = (row_q > RowW'(1)) && (col_q > ColW'(1));
        owed_d = last_pix ? (OwedW'(wlast_q) + OwedW'(2)) : '0;
        if (col_q == wlast_q) begin
          col_d = '0;
          row_d = (row_q == hlast_q) ? '0 : row_q + RowW'(1);
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q     <= ColW'(WLastReset);
      hlast_q     <= RowW'(HLastReset);
      col_q       <= '0;
      row_q       <= '0;
      owed_q      <= '0;
      s1_valid_q  <= 1'b0;
      s1_ctrl_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wlast_q <= wlast_d;
      hlast_q <= hlast_d;
      col_q   <= col_d;
      row_q   <= row_d;
      owed_q  <= owed_d;
      if (pipe_en) begin
        s1_valid_q  <= in_acc;
        s1_ctrl_q   <= s1_ctrl_d;
        out_valid_q <= s1_valid_q && s1_ctrl_q.has_out;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_gray_q  <= gray;
      s1_col_q   <= col_q;
      out_edge_q <= win_edge;
      out_last_q <= s1_ctrl_q.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_edge_q;
  assign m_axis_tlast  = out_last_q;

  a_owed_at_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (owed_q != '0) |-> ((row_q == '0) && (col_q == '0)))
    else $error("Border zeros owed away from the frame start.");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= wlast_q)
    else $error("Column counter beyond the row width.");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= hlast_q)
    else $error("Row counter beyond the frame height.");

  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == '0))
    else $error("Frame end carries a nonzero edge value.");

  a_flush_no_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_ctrl_q.pix) |-> !s1_ctrl_q.interior)
    else $error("Flush transaction marked as an interior pixel.");

endmodule

// ===== sim/laplacian_edge_filter_3x3_core_test.sv =====
// Self-checking testbench for laplacian_edge_filter_3x3_core: random color pixel streams
// over several image sizes, predicted in a scoreboard class and compared with every result.
// Depends on lef_pkg and the filter RTL only.
module laplacian_edge_filter_3x3_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lef_pkg::*;

  localparam int MaxWidth    = MaxWidthDefault;
  localparam int MaxHeight   = MaxHeightDefault;
  localparam int StallLimit  = 2000;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [PixW-1:0] value;
    logic            frame_end;
  } edge_out_t;

  class laplacian_scoreboard;
    logic [PixW-1:0]       upper_row [MaxWidth];
    logic [PixW-1:0]       lower_row [MaxWidth];
    logic [PixW-1:0]       window [9];
    logic [WidthRegW-1:0]  width_reg;
    logic [HeightRegW-1:0] height_reg;
    int unsigned           in_row;
    int unsigned           in_col;
    int unsigned           out_index;
    edge_out_t             expected_edges [$];
    int                    mismatches;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      width_reg  = WidthRegW'(SizeReset);
      height_reg = HeightRegW'(SizeReset);
      in_row     = 0;
      in_col     = 0;
      out_index  = 0;
      mismatches = 0;
    endfunction

    function int unsigned frame_cols();
      if (width_reg < MinSize) return MinSize;
      if (width_reg > MaxWidth) return MaxWidth;
      return width_reg;
    endfunction

    function int unsigned frame_rows();
      if (height_reg < MinSize) return MinSize;
      if (height_reg > MaxHeight) return MaxHeight;
      return height_reg;
    endfunction

    function void write_size(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      if (idx == RegImageWidth) width_reg = data[WidthRegW-1:0];
      else height_reg = data[HeightRegW-1:0];
      in_row    = 0;
      in_col    = 0;
      out_index = 0;
    endfunction

    function void predict_from_item(cmd_e cmd, logic [23:0] rgb);
      int unsigned w, h, total, c, n, idx, sum;
      int          lap;
      int          k;
      logic [PixW-1:0] gray;
      edge_out_t   res;
      w     = frame_cols();
      h     = frame_rows();
      total = w * h;
      if (cmd == CmdFlush) begin
        if (in_row != 0 || in_col != 0 || out_index == 0) return;
        res.value     = '0;
        res.frame_end = (out_index == total - 1);
        expected_edges.push_back(res);
        out_index = (out_index + 1 >= total) ? 0 : out_index + 1;
        return;
      end
      if (in_row == 0 && in_col == 0) out_index = 0;
      sum  = int'(rgb[7:0]) + int'(rgb[15:8]) + int'(rgb[23:16]);
      sum  = sum / 3;
      gray = sum[PixW-1:0];
      c    = (in_col >= w) ? w - 1 : in_col;
      for (k = 0; k < 3; k++) begin
        window[k*3]   = window[k*3+1];
        window[k*3+1] = window[k*3+2];
      end
      window[2]    = upper_row[c];
      window[5]    = lower_row[c];
      window[8]    = gray;
      upper_row[c] = lower_row[c];
      lower_row[c] = gray;
      n      = in_row * w + c;
      in_col = c + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      if (n < w + 1) return;
      idx           = n - w - 1;
      res.value     = '0;
      res.frame_end = (idx == total - 1);
      if (idx / w != 0 && idx / w != h - 1 && idx % w != 0 && idx % w != w - 1) begin
        lap = int'(window[1]) + int'(window[7]) + int'(window[3]) + int'(window[5])
              - 4 * int'(window[4]);
        if (lap > 0) res.value = lap[PixW-1:0];
      end
      expected_edges.push_back(res);
      out_index = idx + 1;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= ReportLimit) $display("%0t: mismatch: %s", $realtime, msg);
    endfunction

    function void check_edge(logic [PixW-1:0] value, logic frame_end);
      edge_out_t want;
      if (expected_edges.size() == 0) begin
        report($sformatf("unexpected result, edge_value %0d frame_end %0b", value, frame_end));
        return;
      end
      want = expected_edges.pop_front();
      if (value !== want.value)
        report($sformatf("edge_value expected %0d, got %0d", want.value, value));
      if (frame_end !== want.frame_end)
        report($sformatf("frame_end expected %0b, got %0b", want.frame_end, frame_end));
    endfunction

    function int pending();
      return expected_edges.size();
    endfunction

    function int failures();
      return mismatches + expected_edges.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = RegImageWidth;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;
  logic                s_axis_tuser  = CmdPixel;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;

  laplacian_scoreboard board = new();
  int          gap_odds     = 4;
  int          stall_odds   = 6;
  int          rx_stall     = 0;
  int          quiet_cycles = 0;
  int unsigned level        = 128;

  laplacian_edge_filter_3x3_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      rx_stall = $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_edge(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        board.predict_from_item(cmd_e'(s_axis_tuser), s_axis_tdata);
      if (cfg_we_i) board.write_size(cfg_reg_e'(cfg_index_i), cfg_data_i);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(cmd_e cmd, logic [23:0] data);
    int gap;
    @(negedge clk_i);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_pixel(logic [23:0] data);
    send_item(CmdPixel, data);
  endtask

  task automatic send_flush();
    logic [31:0] noise;
    noise = $urandom();
    send_item(CmdFlush, noise[23:0]);
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned data);
    hold_until_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[CfgDataW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [23:0] gray_pixel(logic [7:0] v);
    return {v, v, v};
  endfunction

  function automatic logic [23:0] make_pixel(int style);
    logic [31:0] raw;
    int          step;
    logic [7:0]  b, g, r;
    raw = $urandom();
    case (style)
      0: begin
        return raw[23:0];
      end
      1: begin
        b = raw[0] ? 8'hFF : 8'h00;
        g = raw[1] ? 8'hFF : 8'h00;
        r = raw[2] ? 8'hFF : 8'h00;
        return {r, g, b};
      end
      default: begin
        step  = int'(level) + $urandom_range(0, 16) - 8;
        level = (step < 0) ? 0 : (step > 255) ? 255 : step;
        b     = level[7:0];
        g     = level[7:0] ^ {6'd0, raw[1:0]};
        r     = level[7:0] ^ {6'd0, raw[9:8]};
        return {r, g, b};
      end
    endcase
  endfunction

  task automatic run_phase(int unsigned w_raw, int unsigned h_raw, int unsigned pixels,
                           bit calm);
    int unsigned sent, cols, frame_px, count, drain, mode, style, i;
    if (calm) begin
      gap_odds   = 0;
      stall_odds = 0;
    end
    write_reg(RegImageWidth, w_raw);
    write_reg(RegImageHeight, h_raw);
    cols     = board.frame_cols();
    frame_px = cols * board.frame_rows();
    sent     = 0;
    while (sent < pixels) begin
      gap_odds   = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);
      stall_odds = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);
      mode       = $urandom_range(0, 9);
      style      = $urandom_range(0, 2);
      if (mode <= 7) begin
        count = (mode == 7) ? $urandom_range(1, frame_px) : frame_px;
        for (i = 0; i < count && sent < pixels; i++) begin
          if ($urandom_range(0, 31) == 0) send_flush();
          send_pixel(make_pixel(style));
          sent++;
        end
        if (mode < 7 && i == count) begin
          drain = (mode == 6) ? $urandom_range(0, cols) : cols + 1;
          repeat (drain) send_flush();
        end
      end else begin
        repeat (8) begin
          if ($urandom_range(0, 1) == 1) begin
            send_flush();
          end else begin
            send_pixel(make_pixel(style));
            sent++;
          end
        end
      end
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_flush();
    write_reg(RegImageWidth, 1);
    write_reg(RegImageHeight, 2);
    send_pixel(24'h0000FF);
    send_pixel(gray_pixel(8'hFF));
    send_pixel(24'h00FF00);
    send_pixel(gray_pixel(8'hFF));
    send_pixel(gray_pixel(8'h00));
    send_pixel(gray_pixel(8'hFF));
    send_flush();
    send_pixel(24'hFF0000);
    send_pixel(gray_pixel(8'hFF));
    send_pixel(24'h010202);
    repeat (4) send_flush();
    send_flush();
    send_pixel(gray_pixel(8'h00));
    send_pixel(gray_pixel(8'h40));
    send_pixel(gray_pixel(8'h00));
    send_pixel(gray_pixel(8'h40));
    send_pixel(gray_pixel(8'h00));
    send_pixel(gray_pixel(8'h40));
    send_pixel(gray_pixel(8'h00));
    send_pixel(gray_pixel(8'h40));
    send_pixel(gray_pixel(8'h00));
    repeat (2) send_flush();
    send_pixel(gray_pixel(8'h80));
    send_flush();

    run_phase(0, 1, 80, 1'b0);
    run_phase(5, 4, 110, 1'b0);
    run_phase(17, 6, 110, 1'b0);
    run_phase(100, 100, 110, 1'b0);
    run_phase(2047, 2, 1030, 1'b0);
    run_phase(3, 8191, 50, 1'b0);
    run_phase(6, 5, 110, 1'b1);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.failures() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lef_pkg.sv
src/lef_gray.sv
src/lef_line_store.sv
src/lef_window.sv
src/laplacian_edge_filter_3x3_core.sv
sim/laplacian_edge_filter_3x3_core_test.sv
